>>> design/tsa_pkg.sv
package tsa_pkg;

	typedef enum logic [1:0] {
		FN_REGISTER   = 2'd0,
		FN_UNREGISTER = 2'd1,
		FN_QUERY      = 2'd2,
		FN_RESERVED   = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_LARGE     = 3'd2,
		ST_CHANNELS  = 3'd3,
		ST_BADHANDLE = 3'd4,
		ST_FULL      = 3'd5
	} status_t;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 11;
	localparam int unsigned SCALE_ONE = 1024;
	localparam int unsigned IMG_TEX_W = 4;
	localparam int unsigned IMG_LAYER_W = 10;
	localparam int unsigned IMG_SCALE_W = 11;
	localparam int unsigned IMG_HANDLE_W = 10;

	typedef struct packed {
		logic [1:0]  func;
		logic [10:0] img_width;
		logic [10:0] img_height;
		logic [2:0]  img_channels;
		logic [9:0]  req_handle;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [9:0]  out_handle;
		logic [3:0]  out_texture;
		logic [9:0]  out_slice;
		logic [10:0] scale_x;
		logic [10:0] scale_y;
	} rsp_t;

	// one image table entry: live, texture, layer, scales
	typedef struct packed {
		logic        live;
		logic [3:0]  tex;
		logic [9:0]  layer;
		logic [10:0] sx;
		logic [10:0] sy;
	} img_ent_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_SCAN_RD,
		S_DECIDE,
		S_SLICE_RD,
		S_HANDLE,
		S_HANDLE_RD,
		S_WRITE,
		S_IMG_RD,
		S_IMG_USE,
		S_OUT
	} fsm_t;

endpackage

>>> design/tsa_if.sv
interface tsa_req_if;
	import tsa_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tsa_rsp_if;
	import tsa_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> design/texture_slot_allocator_top.sv
// channel | dir | payload
// req     | in  | func, img_width, img_height, img_channels, req_handle
// rsp     | out | status, out_handle, out_texture, out_slice, scale_x, scale_y
// cfg     | in  | cfg_we, cfg_idx, cfg_data (cap_class0..3)
// one item at a time; query/unregister read the image memory, register scans
// the texture table serially, one entry per step (up to 16), then reads the
// slice and handle stacks; the image and stack memories have registered reads.
// after reset a clearing pass walks every entry of the image memory
// and no item is accepted meanwhile; a waiting result blocks the next item.
module texture_slot_allocator_top #(
	parameter int unsigned MAX_IMAGES = 1024,
	parameter int unsigned MAX_TEXTURES = 16,
	parameter int unsigned MAX_SLICES = 1024,
	parameter int unsigned NUM_CLASSES = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	tsa_req_if.sink                         req,
	tsa_rsp_if.source                       rsp,
	input  logic                            cfg_we,
	input  logic [tsa_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [tsa_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import tsa_pkg::*;

	localparam int unsigned HW = (MAX_IMAGES > 1) ? $clog2(MAX_IMAGES) : 1;
	localparam int unsigned HCW = $clog2(MAX_IMAGES + 1);
	localparam int unsigned TW = (MAX_TEXTURES > 1) ? $clog2(MAX_TEXTURES) : 1;
	localparam int unsigned TCW = $clog2(MAX_TEXTURES + 1);
	localparam int unsigned SW = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
	localparam int unsigned SCW = $clog2(MAX_SLICES + 1);
	localparam int unsigned NCL = (NUM_CLASSES < 1) ? 1 : ((NUM_CLASSES > 8) ? 8 : NUM_CLASSES);
	localparam int unsigned SSW = TW + SW;

	// class sizes, indices beyond the list use 1024
	function automatic logic [10:0] class_size(input logic [2:0] c);
		case (c)
			3'd0: class_size = 11'd64;
			3'd1: class_size = 11'd256;
			3'd2: class_size = 11'd512;
			default: class_size = 11'd1024;
		endcase
	endfunction

	// shift amount for (side << 10) / size
	function automatic logic [10:0] scale_of(input logic [10:0] v, input logic [2:0] c);
		case (c)
			3'd0: scale_of = v << 4;
			3'd1: scale_of = v << 2;
			3'd2: scale_of = v << 1;
			default: scale_of = v;
		endcase
	endfunction

	// config registers
	logic [10:0] cap_q [4];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q[0] <= 11'd1024;
			cap_q[1] <= 11'd1024;
			cap_q[2] <= 11'd1024;
			cap_q[3] <= 11'd256;
		end else if (cfg_we) begin
			cap_q[cfg_idx] <= cfg_data;
		end
	end

	// memories
	img_ent_t img_mem [MAX_IMAGES];
	logic [HW-1:0] hstk_mem [MAX_IMAGES];
	logic [SW-1:0] sstk_mem [MAX_TEXTURES*MAX_SLICES];

	logic          img_we;
	logic [HW-1:0] img_wa, img_ra;
	img_ent_t      img_wd, img_rd_q;
	logic          hs_we;
	logic [HW-1:0] hs_wa, hs_ra, hs_rd_q, hs_wd;
	logic          ss_we;
	logic [SSW-1:0] ss_wa, ss_ra;
	logic [SW-1:0] ss_wd, ss_rd_q;

	always_ff @(posedge clk) begin
		if (img_we) img_mem[img_wa] <= img_wd;
		img_rd_q <= img_mem[img_ra];
		if (hs_we) hstk_mem[hs_wa] <= hs_wd;
		hs_rd_q <= hstk_mem[hs_ra];
		if (ss_we) sstk_mem[ss_wa] <= ss_wd;
		ss_rd_q <= sstk_mem[ss_ra];
	end

	// texture table in flops
	logic [4:0]     key_q [MAX_TEXTURES];
	logic [SCW-1:0] depth_q [MAX_TEXTURES];
	logic [SCW-1:0] stop_q [MAX_TEXTURES];
	logic [TCW-1:0] tcount_q;
	logic [HCW-1:0] hwater_q, htop_q;

	// control state
	fsm_t state_q, state_d;
	req_t req_q;
	rsp_t rsp_q;
	logic rsp_valid_q;
	logic [HW:0] clr_q;
	logic [TCW-1:0] scan_q;
	logic [2:0] cl_q;
	logic [4:0] keyv_q;
	logic [TW-1:0] tsel_q;
	logic found_q, pop_slice_q;
	logic [SW-1:0] slice_q;
	logic [HW-1:0] hd_q;
	logic [SCW-1:0] capv_q;
	logic hs_rd_sel_q;

	wire clearing = !clr_q[HW];
	assign req.ready = (state_q == S_IDLE) && !rsp_valid_q && !clearing;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data = rsp_q;

	// request decode
	logic [10:0] big, maxsz;
	logic [2:0] cl_c;
	always_comb begin
		big = (req_q.img_width > req_q.img_height) ? req_q.img_width : req_q.img_height;
		maxsz = class_size(3'(NCL - 1));
		cl_c = 3'(NCL - 1);
		for (int i = NCL - 2; i >= 0; i--) begin
			if (big <= class_size(3'(i))) cl_c = 3'(i);
		end
	end

	wire handle_in_range = (32'(req_q.req_handle) < 32'(hwater_q))
		&& (32'(req_q.req_handle) < MAX_IMAGES);
	wire [TW-1:0] scan_idx = scan_q[TW-1:0];
	wire scan_hit = (key_q[scan_idx] == keyv_q)
		&& ((stop_q[scan_idx] != '0) || (depth_q[scan_idx] < capv_q));

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (req.valid && req.ready) state_d = S_CHECK;
			S_CHECK: begin
				if (req_q.func == FN_REGISTER) state_d = S_SCAN;
				else state_d = S_IMG_RD;
			end
			S_SCAN: state_d = S_SCAN_RD;
			S_SCAN_RD: begin
				if (scan_hit || (32'(scan_q) + 1 >= 32'(tcount_q))
					|| (32'(scan_q) + 1 >= MAX_TEXTURES)) state_d = S_DECIDE;
				else state_d = S_SCAN;
			end
			S_DECIDE: state_d = S_SLICE_RD;
			S_SLICE_RD: state_d = S_HANDLE;
			S_HANDLE: state_d = S_HANDLE_RD;
			S_HANDLE_RD: state_d = S_WRITE;
			S_WRITE: state_d = S_OUT;
			S_IMG_RD: state_d = S_IMG_USE;
			S_IMG_USE: state_d = S_OUT;
			S_OUT: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// datapath and bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			clr_q <= '0;
			tcount_q <= TCW'(1);
			hwater_q <= HCW'(1);
			htop_q <= '0;
			// entry 0 holds four channels, class 0; the key keeps channels mod 4
			for (int i = 0; i < MAX_TEXTURES; i++) begin
				key_q[i] <= '0;
				depth_q[i] <= (i == 0) ? SCW'(1) : '0;
				stop_q[i] <= '0;
			end
		end else begin
			if (clearing) clr_q <= clr_q + 1'b1;
			if (rsp.valid && rsp.ready) rsp_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (req.valid && req.ready) req_q <= req.data;
				S_CHECK: begin
					rsp_q.out_texture <= '0;
					rsp_q.out_slice <= '0;
					rsp_q.scale_x <= '0;
					rsp_q.scale_y <= '0;
					cl_q <= cl_c;
					keyv_q <= {req_q.img_channels[1:0], cl_c};
					capv_q <= (32'(cap_q[(cl_c < 3'd4) ? cl_c[1:0] : 2'd3]) > MAX_SLICES)
						? SCW'(MAX_SLICES) : SCW'(cap_q[(cl_c < 3'd4) ? cl_c[1:0] : 2'd3]);
					scan_q <= '0;
					found_q <= 1'b0;
					if (req_q.func == FN_REGISTER) begin
						rsp_q.out_handle <= '0;
						if (req_q.img_width == 0 || req_q.img_height == 0
							|| req_q.img_channels == 0) begin
							rsp_q.status <= ST_EMPTY;
						end else if (req_q.img_width > maxsz || req_q.img_height > maxsz) begin
							rsp_q.status <= ST_LARGE;
						end else if (req_q.img_channels > 3'd4) begin
							rsp_q.status <= ST_CHANNELS;
						end else begin
							rsp_q.status <= ST_OK;
						end
					end else begin
						rsp_q.status <= ST_OK;
						rsp_q.out_handle <= req_q.req_handle;
					end
				end
				S_SCAN_RD: begin
					if (scan_hit && !found_q) begin
						found_q <= 1'b1;
						tsel_q <= scan_idx;
					end else if (!found_q) begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_DECIDE: begin
					if (rsp_q.status == ST_OK) begin
						if (!found_q && 32'(tcount_q) >= MAX_TEXTURES) rsp_q.status <= ST_FULL;
						else if (htop_q == '0 && 32'(hwater_q) >= MAX_IMAGES) rsp_q.status <= ST_FULL;
						else if (!found_q) begin
							tsel_q <= tcount_q[TW-1:0];
							key_q[tcount_q[TW-1:0]] <= keyv_q;
							depth_q[tcount_q[TW-1:0]] <= '0;
							stop_q[tcount_q[TW-1:0]] <= '0;
							tcount_q <= tcount_q + 1'b1;
						end
					end
				end
				S_SLICE_RD: if (rsp_q.status == ST_OK) begin
					pop_slice_q <= stop_q[tsel_q] != '0;
					if (stop_q[tsel_q] != '0) stop_q[tsel_q] <= stop_q[tsel_q] - 1'b1;
					else begin
						slice_q <= depth_q[tsel_q][SW-1:0];
						depth_q[tsel_q] <= depth_q[tsel_q] + 1'b1;
					end
				end
				S_HANDLE: if (rsp_q.status == ST_OK) begin
					if (pop_slice_q) slice_q <= ss_rd_q;
					if (htop_q != '0) htop_q <= htop_q - 1'b1;
					else begin
						hd_q <= hwater_q[HW-1:0];
						hwater_q <= hwater_q + 1'b1;
					end
				end
				S_HANDLE_RD: if (rsp_q.status == ST_OK) begin
					if (hs_rd_sel_q) hd_q <= hs_rd_q;
				end
				S_WRITE: if (rsp_q.status == ST_OK) begin
					rsp_q.out_handle <= 10'(hd_q);
					rsp_q.out_texture <= 4'(tsel_q);
					rsp_q.out_slice <= 10'(slice_q);
					rsp_q.scale_x <= scale_of(req_q.img_width, cl_q);
					rsp_q.scale_y <= scale_of(req_q.img_height, cl_q);
				end
				S_IMG_USE: begin
					if (req_q.func == FN_RESERVED || !handle_in_range || !img_rd_q.live) begin
						rsp_q.status <= ST_BADHANDLE;
					end else begin
						rsp_q.out_texture <= img_rd_q.tex;
						rsp_q.out_slice <= img_rd_q.layer;
						rsp_q.scale_x <= img_rd_q.sx;
						rsp_q.scale_y <= img_rd_q.sy;
						if (req_q.func == FN_UNREGISTER) begin
							if (32'(stop_q[img_rd_q.tex[TW-1:0]]) < MAX_SLICES)
								stop_q[img_rd_q.tex[TW-1:0]] <= stop_q[img_rd_q.tex[TW-1:0]] + 1'b1;
							if (32'(htop_q) < MAX_IMAGES) htop_q <= htop_q + 1'b1;
						end
					end
				end
				S_OUT: rsp_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// handle pop came from the stack
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) hs_rd_sel_q <= 1'b0;
		else if (state_q == S_HANDLE) hs_rd_sel_q <= htop_q != '0;
	end

	// stack pops read the entry just below the top
	wire [SCW-1:0] stop_dec = stop_q[tsel_q] - 1'b1;
	wire [HCW-1:0] htop_dec = htop_q - 1'b1;

	// memory port control
	wire unreg_ok = (state_q == S_IMG_USE) && req_q.func == FN_UNREGISTER
		&& handle_in_range && img_rd_q.live;
	wire [TW-1:0] ut = img_rd_q.tex[TW-1:0];
	always_comb begin
		img_we = 1'b0;
		img_wa = hd_q;
		img_wd = img_ent_t'{1'b1, 4'(tsel_q), 10'(slice_q),
			scale_of(req_q.img_width, cl_q), scale_of(req_q.img_height, cl_q)};
		img_ra = req_q.req_handle[HW-1:0];
		if (clearing) begin
			img_we = 1'b1;
			img_wa = clr_q[HW-1:0];
			img_wd = img_ent_t'{clr_q[HW-1:0] == '0, 4'd0, 10'd0, 11'd1024, 11'd1024};
		end else if (state_q == S_WRITE && rsp_q.status == ST_OK) begin
			img_we = 1'b1;
		end else if (unreg_ok) begin
			img_we = 1'b1;
			img_wa = req_q.req_handle[HW-1:0];
			img_wd = img_ent_t'{1'b0, 4'd0, 10'd0, 11'd1024, 11'd1024};
		end
		hs_we = unreg_ok && (32'(htop_q) < MAX_IMAGES);
		hs_wa = htop_q[HW-1:0];
		hs_ra = htop_dec[HW-1:0];
		ss_we = unreg_ok && (32'(stop_q[ut]) < MAX_SLICES);
		ss_wa = {ut, stop_q[ut][SW-1:0]};
		ss_wd = img_rd_q.layer[SW-1:0];
		ss_ra = {tsel_q, stop_dec[SW-1:0]};
	end
	assign hs_wd = req_q.req_handle[HW-1:0];

endmodule

>>> test/tsa_checker.sv
module tsa_checker
	import tsa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	tsa_req_if                    req,
	tsa_rsp_if                    rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    errors,
	output int                    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_IMG = 1024;
	localparam int N_TEX = 16;
	localparam int N_SLC = 1024;

	// allocator mirror
	logic [10:0] cap [4];
	logic        live [N_IMG];
	logic [3:0]  itex [N_IMG];
	logic [9:0]  ilayer [N_IMG];
	logic [10:0] isx [N_IMG];
	logic [10:0] isy [N_IMG];
	int          high_water;
	int          free_handles [$];
	int          tex_num;
	int          tkey [N_TEX];
	int          tdepth [N_TEX];
	int          free_slices [N_TEX][$];
	rsp_t        expected_rsp [$];

	function automatic int class_px(int cl);
		case (cl)
			0: return 64;
			1: return 256;
			2: return 512;
			default: return 1024;
		endcase
	endfunction

	function automatic int cap_limit(int cl);
		return (cap[cl] > N_SLC) ? N_SLC : int'(cap[cl]);
	endfunction

	function automatic rsp_t mk(status_t st, int h, int t, int s, int sx, int sy);
		rsp_t r;
		r.status = st;
		r.out_handle = h[9:0];
		r.out_texture = t[3:0];
		r.out_slice = s[9:0];
		r.scale_x = sx[10:0];
		r.scale_y = sy[10:0];
		return r;
	endfunction

	function automatic bit handle_live(int h);
		return h < high_water && live[h];
	endfunction

	function automatic rsp_t alloc_slot(int w, int h, int ch);
		int big, cl, key, t, slice, hd, i;
		if (w == 0 || h == 0 || ch == 0) return mk(ST_EMPTY, 0, 0, 0, 0, 0);
		if (w > 1024 || h > 1024) return mk(ST_LARGE, 0, 0, 0, 0, 0);
		if (ch > 4) return mk(ST_CHANNELS, 0, 0, 0, 0, 0);
		big = (w > h) ? w : h;
		cl = 0;
		while (cl < 3 && big > class_px(cl)) cl++;
		key = ch * 8 + cl;
		t = tex_num;
		for (i = 0; i < tex_num; i++)
			if (tkey[i] == key && (free_slices[i].size() > 0 || tdepth[i] < cap_limit(cl))) begin
				t = i;
				break;
			end
		if (t >= tex_num && tex_num >= N_TEX) return mk(ST_FULL, 0, 0, 0, 0, 0);
		if (free_handles.size() == 0 && high_water >= N_IMG) return mk(ST_FULL, 0, 0, 0, 0, 0);
		// open a new texture array
		if (t >= tex_num) begin
			tkey[t] = key;
			tdepth[t] = 0;
			free_slices[t].delete();
			tex_num++;
		end
		// most recently freed slice first
		if (free_slices[t].size() > 0) begin
			slice = free_slices[t][$];
			free_slices[t].delete(free_slices[t].size() - 1);
		end else begin
			slice = tdepth[t];
			tdepth[t]++;
		end
		if (free_handles.size() > 0) begin
			hd = free_handles[$];
			free_handles.delete(free_handles.size() - 1);
		end else begin
			hd = high_water;
			high_water++;
		end
		live[hd] = 1;
		itex[hd] = t[3:0];
		ilayer[hd] = slice[9:0];
		isx[hd] = 11'((w << 10) / class_px(cl));
		isy[hd] = 11'((h << 10) / class_px(cl));
		return mk(ST_OK, hd, t, slice, isx[hd], isy[hd]);
	endfunction

	function automatic rsp_t serve(req_t q);
		int h;
		rsp_t r;
		h = q.req_handle;
		case (func_t'(q.func))
			FN_REGISTER: return alloc_slot(q.img_width, q.img_height, q.img_channels);
			FN_UNREGISTER: begin
				if (!handle_live(h)) return mk(ST_BADHANDLE, h, 0, 0, 0, 0);
				r = mk(ST_OK, h, itex[h], ilayer[h], isx[h], isy[h]);
				free_slices[itex[h]].insert(free_slices[itex[h]].size(), ilayer[h]);
				live[h] = 0;
				itex[h] = 0;
				ilayer[h] = 0;
				isx[h] = 1024;
				isy[h] = 1024;
				free_handles.insert(free_handles.size(), h);
				return r;
			end
			FN_QUERY: begin
				if (!handle_live(h)) return mk(ST_BADHANDLE, h, 0, 0, 0, 0);
				return mk(ST_OK, h, itex[h], ilayer[h], isx[h], isy[h]);
			end
			default: return mk(ST_BADHANDLE, h, 0, 0, 0, 0);
		endcase
	endfunction

	task automatic report(string field, int got, int want);
		$display("%0t: %s got %0d expected %0d", $realtime, field, got, want);
		errors++;
	endtask

	// reset state
	initial begin
		errors = 0;
		cap = '{11'd1024, 11'd1024, 11'd1024, 11'd256};
		for (int i = 0; i < N_IMG; i++) begin
			live[i] = 0;
			itex[i] = 0;
			ilayer[i] = 0;
			isx[i] = 0;
			isy[i] = 0;
		end
		live[0] = 1;
		isx[0] = 1024;
		isy[0] = 1024;
		high_water = 1;
		tex_num = 1;
		for (int i = 0; i < N_TEX; i++) begin
			tkey[i] = 0;
			tdepth[i] = 0;
		end
		tkey[0] = 4 * 8;
		tdepth[0] = 1;
	end

	assign pending = expected_rsp.size();

	// predict on request transfer, compare on response transfer
	always @(posedge clk) begin
		rsp_t want, got;
		if (arst_n) begin
			if (cfg_we) cap[cfg_idx] = cfg_data;
			if (req.valid && req.ready)
				expected_rsp.insert(expected_rsp.size(), serve(req.data));
			if (rsp.valid && rsp.ready) begin
				got = rsp.data;
				if (expected_rsp.size() == 0) report("unexpected response, status", got.status, -1);
				else begin
					want = expected_rsp.pop_front();
					if (got.status != want.status) report("status", got.status, want.status);
					if (got.out_handle != want.out_handle)
						report("out_handle", got.out_handle, want.out_handle);
					if (got.out_texture != want.out_texture)
						report("out_texture", got.out_texture, want.out_texture);
					if (got.out_slice != want.out_slice)
						report("out_slice", got.out_slice, want.out_slice);
					if (got.scale_x != want.scale_x) report("scale_x", got.scale_x, want.scale_x);
					if (got.scale_y != want.scale_y) report("scale_y", got.scale_y, want.scale_y);
				end
			end
		end
	end
endmodule

>>> test/texture_slot_allocator_top_test.sv
module texture_slot_allocator_top_test;
	import tsa_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  rsp_ready_q = 1'b0;
	bit                    idle_on = 1'b1;
	int                    stall_left = 0;
	int                    errors;
	int                    pending;

	tsa_req_if req_ch ();
	tsa_rsp_if rsp_ch ();

	assign rsp_ch.ready = rsp_ready_q;

	texture_slot_allocator_top DUT (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	tsa_checker checker_i (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// response back-pressure in bursts
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp_ready_q <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 10);
			rsp_ready_q <= 1'b0;
		end else begin
			rsp_ready_q <= 1'b1;
		end
	end

	function automatic req_t mk_req(func_t f, int w, int h, int ch, int hd);
		req_t q;
		q.func = f;
		q.img_width = w[10:0];
		q.img_height = h[10:0];
		q.img_channels = ch[2:0];
		q.req_handle = hd[9:0];
		return q;
	endfunction

	// one request transfer, with an optional gap ahead of it
	task automatic send(req_t q);
		int n;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 11);
			@(negedge clk);
			req_ch.valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.data <= q;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic drain();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_caps(int c0, int c1, int c2, int c3);
		int v [4];
		v = '{c0, c1, c2, c3};
		drain();
		for (int i = 0; i < 4; i++) begin
			@(negedge clk);
			cfg_we <= 1'b1;
			cfg_idx <= i[CFG_IDX_W-1:0];
			cfg_data <= v[i][CFG_DATA_W-1:0];
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic req_t random_req();
		int sel, cl, side, hd;
		sel = $urandom_range(0, 99);
		hd = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 48);
		if (sel < 45) begin
			// well-formed image sized to a random class
			cl = $urandom_range(0, 3);
			side = (cl == 0) ? 64 : (cl == 1) ? 256 : (cl == 2) ? 512 : 1024;
			return mk_req(FN_REGISTER, $urandom_range(1, side), $urandom_range(1, side),
				$urandom_range(1, 4), hd);
		end else if (sel < 52) begin
			return mk_req(FN_REGISTER, $urandom_range(0, 2047), $urandom_range(0, 2047),
				$urandom_range(0, 7), hd);
		end else if (sel < 77) begin
			return mk_req(FN_UNREGISTER, $urandom_range(0, 2047), $urandom_range(0, 2047),
				$urandom_range(0, 7), hd);
		end else if (sel < 95) begin
			return mk_req(FN_QUERY, $urandom_range(0, 2047), $urandom_range(0, 2047),
				$urandom_range(0, 7), hd);
		end
		return mk_req(FN_RESERVED, $urandom_range(0, 2047), $urandom_range(0, 2047),
			$urandom_range(0, 7), hd);
	endfunction

	task automatic random_run(int n);
		for (int i = 0; i < n; i++) send(random_req());
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: classes, rejections, default image, bad handles
		send(mk_req(FN_QUERY, 0, 0, 0, 0));
		send(mk_req(FN_REGISTER, 64, 64, 4, 0));
		send(mk_req(FN_REGISTER, 1, 1, 1, 0));
		send(mk_req(FN_REGISTER, 1024, 1024, 4, 0));
		send(mk_req(FN_REGISTER, 65, 1, 2, 0));
		send(mk_req(FN_REGISTER, 3, 257, 3, 0));
		send(mk_req(FN_REGISTER, 513, 600, 4, 0));
		send(mk_req(FN_REGISTER, 0, 10, 1, 0));
		send(mk_req(FN_REGISTER, 10, 0, 1, 0));
		send(mk_req(FN_REGISTER, 10, 10, 0, 0));
		send(mk_req(FN_REGISTER, 1025, 5, 1, 0));
		send(mk_req(FN_REGISTER, 5, 2047, 7, 0));
		send(mk_req(FN_REGISTER, 5, 5, 5, 0));
		send(mk_req(FN_REGISTER, 2047, 2047, 7, 1023));
		send(mk_req(FN_QUERY, 2047, 2047, 7, 1023));
		send(mk_req(FN_UNREGISTER, 0, 0, 0, 0));
		send(mk_req(FN_QUERY, 0, 0, 0, 0));
		send(mk_req(FN_UNREGISTER, 0, 0, 0, 0));
		send(mk_req(FN_RESERVED, 0, 0, 0, 5));
		send(mk_req(FN_REGISTER, 32, 64, 4, 0));
		send(mk_req(FN_UNREGISTER, 0, 0, 0, 2));
		send(mk_req(FN_REGISTER, 200, 100, 2, 0));
		random_run(150);

		// exhaust the handle table, then release the low handles
		for (int i = 0; i < 1040; i++)
			send(mk_req(FN_REGISTER, $urandom_range(1, 64), $urandom_range(1, 64), 4, 0));
		for (int i = 0; i < 200; i++) send(mk_req(FN_UNREGISTER, 0, 0, 0, i));

		write_caps(1, 1, 1, 1);
		random_run(50);
		write_caps(2047, 1024, 3, 1);
		random_run(50);
		write_caps(0, 0, 0, 0);
		random_run(40);
		idle_on = 1'b0;
		random_run(50);

		// wait for the last responses
		@(negedge clk);
		req_ch.valid <= 1'b0;
		for (int i = 0; i < 200000 && pending != 0; i++) @(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// watchdog
	initial begin
		#50ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
